// ===== design/hrhs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the HTTP reply header stripper.
package hrhs_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned STATUS_W  = 10;
   localparam int unsigned VERDICT_W = 3;

   localparam logic [STATUS_W-1:0] STATUS_MAX   = 10'd999;
   localparam logic [STATUS_W-1:0] STATUS_RESET = 10'd200;

   localparam logic [BYTE_W-1:0] CH_CR  = 8'd13;
   localparam logic [BYTE_W-1:0] CH_LF  = 8'd10;
   localparam logic [BYTE_W-1:0] CH_DOT = 8'd46;

   localparam logic [2:0] PREFIX_LEN = 3'd5;

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_OK       = 3'd0,
      VERDICT_NO_LINE  = 3'd1,
      VERDICT_BAD_LINE = 3'd2,
      VERDICT_WRONG    = 3'd3,
      VERDICT_UNTERM   = 3'd4
   } verdict_type;

   typedef enum logic [7:0] {
      PH_PREFIX  = 8'b0000_0001,
      PH_VERSION = 8'b0000_0010,
      PH_GAP     = 8'b0000_0100,
      PH_DIGITS  = 8'b0000_1000,
      PH_REST    = 8'b0001_0000,
      PH_HEADERS = 8'b0010_0000,
      PH_BODY    = 8'b0100_0000,
      PH_REJECT  = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
   } req_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0]    body_byte;
      logic                 body_valid;
      logic                 reply_done;
      logic [VERDICT_W-1:0] verdict;
      logic [STATUS_W-1:0]  status_code;
   } rsp_item_type;

   function automatic logic is_space(logic [BYTE_W-1:0] c);
      return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_digit(logic [BYTE_W-1:0] c);
      return (c >= 8'd48) && (c <= 8'd57);
   endfunction

   function automatic logic [BYTE_W-1:0] prefix_char(logic [2:0] pos);
      logic [BYTE_W-1:0] r;
      case (pos)
         3'd0: r = 8'h48;
         3'd1: r = 8'h54;
         3'd2: r = 8'h54;
         3'd3: r = 8'h50;
         3'd4: r = 8'h2F;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

// ===== design/hrhs_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the request bytes and the reply results.
interface hrhs_req_if;
   logic                         valid;
   logic                         ready;
   logic [hrhs_pkg::BYTE_W-1:0] data_byte;
   logic                         last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hrhs_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [hrhs_pkg::BYTE_W-1:0]    body_byte;
   logic                            body_valid;
   logic                            reply_done;
   logic [hrhs_pkg::VERDICT_W-1:0] verdict;
   logic [hrhs_pkg::STATUS_W-1:0]  status_code;

   modport source (output valid, output body_byte, output body_valid, output reply_done,
                   output verdict, output status_code, input ready);
   modport sink (input valid, input body_byte, input body_valid, input reply_done,
                 input verdict, input status_code, output ready);
endinterface

// ===== design/hrhs_in_stage.sv =====
`timescale 1ns / 1ps
// Input register that captures one request byte per transfer.
module hrhs_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   hrhs_req_if.sink               req_chan,
   input  logic                   advance,
   output hrhs_pkg::req_item_type item,
   output logic                   item_valid
);

   logic                   valid_ff;
   logic                   valid_in;
   hrhs_pkg::req_item_type item_ff;
   logic                   take;

   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.data_byte <= req_chan.data_byte;
         item_ff.last_byte <= req_chan.last_byte;
      end
   end

   assign item       = item_ff;
   assign item_valid = valid_ff;

endmodule

// ===== design/hrhs_parser.sv =====
`timescale 1ns / 1ps
// Reply parser: status line check, header skip and body pass-through state.
module hrhs_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [hrhs_pkg::STATUS_W-1:0]       csr_write_data,
   input  hrhs_pkg::req_item_type              item,
   input  logic                                advance,
   output hrhs_pkg::rsp_item_type              result,
   output logic                                result_valid
);

   typedef struct packed {
      hrhs_pkg::phase_type             phase;
      logic [2:0]                      prefix_pos;
      logic                            pend_cr;
      logic                            line_empty;
      logic [1:0]                      version_flags;
      logic [hrhs_pkg::STATUS_W-1:0]   acc;
      logic [1:0]                      status_flags;
      hrhs_pkg::verdict_type           error_code;
   } scan_state_type;

   localparam scan_state_type STATE_RESET = '{
      phase:         hrhs_pkg::PH_PREFIX,
      prefix_pos:    3'd0,
      pend_cr:       1'b0,
      line_empty:    1'b1,
      version_flags: 2'b00,
      acc:           '0,
      status_flags:  2'b00,
      error_code:    hrhs_pkg::VERDICT_OK
   };

   scan_state_type                state_ff;
   scan_state_type                state_in;
   logic [hrhs_pkg::STATUS_W-1:0] expected_ff;

   function automatic logic in_status_line(hrhs_pkg::phase_type p);
      return (p == hrhs_pkg::PH_PREFIX) || (p == hrhs_pkg::PH_VERSION) ||
             (p == hrhs_pkg::PH_GAP) || (p == hrhs_pkg::PH_DIGITS) ||
             (p == hrhs_pkg::PH_REST);
   endfunction

   function automatic scan_state_type add_digit(scan_state_type s, logic [3:0] d);
      scan_state_type r;
      logic [13:0]    v;
      r = s;
      v = ({4'd0, s.acc} << 3) + ({4'd0, s.acc} << 1) + {10'd0, d};
      r.status_flags[0] = 1'b1;
      if (v > {4'd0, hrhs_pkg::STATUS_MAX}) begin
         r.acc             = hrhs_pkg::STATUS_MAX;
         r.status_flags[1] = 1'b1;
      end else begin
         r.acc = v[hrhs_pkg::STATUS_W-1:0];
      end
      return r;
   endfunction

   function automatic scan_state_type reject_line(scan_state_type s);
      scan_state_type r;
      r            = s;
      r.error_code = hrhs_pkg::VERDICT_BAD_LINE;
      r.phase      = hrhs_pkg::PH_REST;
      return r;
   endfunction

   // One content byte of the status line.
   function automatic scan_state_type feed(scan_state_type s, logic [hrhs_pkg::BYTE_W-1:0] c);
      scan_state_type r;
      r = s;
      case (s.phase)
         hrhs_pkg::PH_PREFIX: begin
            if (s.prefix_pos < hrhs_pkg::PREFIX_LEN &&
                c == hrhs_pkg::prefix_char(s.prefix_pos)) begin
               r.prefix_pos = s.prefix_pos + 3'd1;
               if (r.prefix_pos == hrhs_pkg::PREFIX_LEN) begin
                  r.phase = hrhs_pkg::PH_VERSION;
               end
            end else begin
               r = reject_line(s);
            end
         end
         hrhs_pkg::PH_VERSION: begin
            if (hrhs_pkg::is_digit(c)) begin
               r.version_flags[0] = 1'b1;
            end else if (c == hrhs_pkg::CH_DOT) begin
               if (s.version_flags[1]) begin
                  r = reject_line(s);
               end else begin
                  r.version_flags[1] = 1'b1;
               end
            end else if (hrhs_pkg::is_space(c) && s.version_flags[0]) begin
               r.phase = hrhs_pkg::PH_GAP;
            end else begin
               r = reject_line(s);
            end
         end
         hrhs_pkg::PH_GAP: begin
            if (hrhs_pkg::is_space(c)) begin
               r = s;
            end else if (!hrhs_pkg::is_digit(c)) begin
               r = reject_line(s);
            end else begin
               r       = add_digit(s, c[3:0]);
               r.phase = hrhs_pkg::PH_DIGITS;
            end
         end
         hrhs_pkg::PH_DIGITS: begin
            if (hrhs_pkg::is_digit(c)) begin
               r = add_digit(s, c[3:0]);
            end else begin
               r.phase = hrhs_pkg::PH_REST;
            end
         end
         default: begin
            r = s;
         end
      endcase
      return r;
   endfunction

   function automatic scan_state_type end_line(scan_state_type s,
                                               logic [hrhs_pkg::STATUS_W-1:0] expected);
      scan_state_type r;
      r = s;
      if (r.error_code == hrhs_pkg::VERDICT_OK &&
          !((s.phase == hrhs_pkg::PH_DIGITS || s.phase == hrhs_pkg::PH_REST) &&
            s.status_flags[0])) begin
         r.error_code = hrhs_pkg::VERDICT_BAD_LINE;
      end
      if (r.error_code == hrhs_pkg::VERDICT_OK) begin
         if (s.status_flags[1] || s.acc != expected) begin
            r.error_code = hrhs_pkg::VERDICT_WRONG;
            r.phase      = hrhs_pkg::PH_REJECT;
         end else begin
            r.phase      = hrhs_pkg::PH_HEADERS;
            r.line_empty = 1'b1;
         end
      end else begin
         r.phase = hrhs_pkg::PH_REJECT;
      end
      return r;
   endfunction

   always_comb begin
      state_in     = state_ff;
      result       = '0;
      result_valid = (state_ff.phase == hrhs_pkg::PH_BODY) || item.last_byte;

      if (in_status_line(state_ff.phase)) begin
         if (state_ff.pend_cr && item.data_byte == hrhs_pkg::CH_LF) begin
            state_in.pend_cr = 1'b0;
            state_in         = end_line(state_in, expected_ff);
         end else begin
            if (state_ff.pend_cr) begin
               state_in = feed(state_in, hrhs_pkg::CH_CR);
            end
            if (item.data_byte == hrhs_pkg::CH_CR) begin
               state_in.pend_cr = 1'b1;
            end else begin
               state_in.pend_cr = 1'b0;
               state_in         = feed(state_in, item.data_byte);
            end
         end
      end else if (state_ff.phase == hrhs_pkg::PH_HEADERS) begin
         if (state_ff.pend_cr && item.data_byte == hrhs_pkg::CH_LF) begin
            state_in.pend_cr = 1'b0;
            if (state_ff.line_empty) begin
               state_in.phase = hrhs_pkg::PH_BODY;
            end else begin
               state_in.line_empty = 1'b1;
            end
         end else begin
            if (state_ff.pend_cr) begin
               state_in.line_empty = 1'b0;
            end
            if (item.data_byte == hrhs_pkg::CH_CR) begin
               state_in.pend_cr = 1'b1;
            end else begin
               state_in.pend_cr    = 1'b0;
               state_in.line_empty = 1'b0;
            end
         end
      end else if (state_ff.phase == hrhs_pkg::PH_BODY) begin
         result.body_byte  = item.data_byte;
         result.body_valid = 1'b1;
      end

      if (item.last_byte) begin
         result.reply_done = 1'b1;
         if (in_status_line(state_in.phase)) begin
            result.verdict = hrhs_pkg::VERDICT_NO_LINE;
         end else if (state_in.phase == hrhs_pkg::PH_HEADERS) begin
            result.verdict     = hrhs_pkg::VERDICT_UNTERM;
            result.status_code = state_in.acc;
         end else if (state_in.phase == hrhs_pkg::PH_BODY) begin
            result.verdict     = hrhs_pkg::VERDICT_OK;
            result.status_code = state_in.acc;
         end else begin
            result.verdict = state_in.error_code;
            if (state_in.error_code == hrhs_pkg::VERDICT_WRONG) begin
               result.status_code = state_in.acc;
            end
         end
         state_in = STATE_RESET;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= hrhs_pkg::STATUS_RESET;
      end else if (csr_write_enable) begin
         expected_ff <= csr_write_data;
      end
   end

   // The end of a reply always leaves the parser at the start of a fresh status line.
   assert property (@(posedge clock) disable iff (reset)
      (advance && item.last_byte) |=>
         (state_ff.phase == hrhs_pkg::PH_PREFIX && state_ff.line_empty && !state_ff.pend_cr))
      else $error("parser state not cleared after end of reply");

   // Body bytes only flow after a matching status line.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == hrhs_pkg::PH_BODY) |-> (state_ff.error_code == hrhs_pkg::VERDICT_OK))
      else $error("body phase reached with an error recorded");

   assert property (@(posedge clock) disable iff (reset)
      (result_valid && result.body_valid) |-> (result.verdict == hrhs_pkg::VERDICT_OK))
      else $error("body byte carries a failing verdict");

   assert property (@(posedge clock) disable iff (reset)
      (result_valid && (result.verdict == hrhs_pkg::VERDICT_NO_LINE ||
                        result.verdict == hrhs_pkg::VERDICT_BAD_LINE))
         |-> (result.status_code == '0))
      else $error("status reported without a valid status line");

endmodule

// ===== design/hrhs_out_stage.sv =====
`timescale 1ns / 1ps
// Result register that holds one result until its transfer completes.
module hrhs_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  hrhs_pkg::rsp_item_type result,
   output logic                   slot_free,
   hrhs_rsp_if.source             rsp_chan
);

   logic                   valid_ff;
   logic                   valid_in;
   hrhs_pkg::rsp_item_type data_ff;

   assign slot_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.body_byte   = data_ff.body_byte;
   assign rsp_chan.body_valid  = data_ff.body_valid;
   assign rsp_chan.reply_done  = data_ff.reply_done;
   assign rsp_chan.verdict     = data_ff.verdict;
   assign rsp_chan.status_code = data_ff.status_code;

endmodule

// ===== design/http_reply_header_stripper.sv =====
`timescale 1ns / 1ps
// Top level of the HTTP reply header stripper.
// A byte taken on req_chan is held in the input register and passes the parser once the output
// register is free or rsp_chan takes its result; its result is then offered from the output register.
// Throughput: one byte per cycle while the output register is free or rsp_chan is ready.
// Bytes that cause no result (status line and headers, unless the byte ends the reply) leave the pipe without output.
// Reset is synchronous and active high; it empties both stages, returns the parser to the
// start of a status line and sets the expected status to 200.
module http_reply_header_stripper (
   input  logic                          clock,
   input  logic                          reset,
   hrhs_req_if.sink                      req_chan,
   hrhs_rsp_if.source                    rsp_chan,
   input  logic                          csr_write_enable,
   input  logic [hrhs_pkg::STATUS_W-1:0] csr_write_data
);

   hrhs_pkg::req_item_type item;
   logic                   item_valid;
   hrhs_pkg::rsp_item_type result;
   logic                   result_valid;
   logic                   slot_free;
   logic                   advance;
   logic                   load;

   assign advance = item_valid && slot_free;
   assign load    = advance && result_valid;

   hrhs_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (advance),
      .item       (item),
      .item_valid (item_valid)
   );

   hrhs_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .item             (item),
      .advance          (advance),
      .result           (result),
      .result_valid     (result_valid)
   );

   hrhs_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .result    (result),
      .slot_free (slot_free),
      .rsp_chan  (rsp_chan)
   );

endmodule
